// ----- src/rarmt_pkg.sv -----
// rarmt_pkg: shared types and constants for the range assign / range max block
// no dependencies
`timescale 1ns / 1ps

package rarmt_pkg;

   localparam int LEAVES_DEF = 1024;
   localparam int VALUE_W    = 32;
   localparam int TAG_W      = 16;
   localparam int RANGE_W    = 10;
   localparam int CSR_W      = 11;

   localparam logic KIND_QUERY  = 1'b0;
   localparam logic KIND_ASSIGN = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [RANGE_W-1:0]        range_low;
      logic [RANGE_W-1:0]        range_high;
      logic signed [VALUE_W-1:0] new_value;
      logic [TAG_W-1:0]          new_tag;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic [TAG_W-1:0]          max_tag;
      logic                      found;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [TAG_W-1:0]          tag;
   } leaf_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

// ----- src/rarmt_leaf_store.sv -----
// rarmt_leaf_store: single-port leaf memory, registered read data
// depends on rarmt_pkg
`timescale 1ns / 1ps

module rarmt_leaf_store #(
   parameter int LEAVES = rarmt_pkg::LEAVES_DEF,
   parameter int IDX_W  = $clog2(LEAVES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    addr,
   input  rarmt_pkg::leaf_type wr_data,
   output rarmt_pkg::leaf_type rd_data
);
   import rarmt_pkg::*;

   leaf_type mem [LEAVES];
   leaf_type rd_data_ff;

   // write or read one leaf per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/range_assign_range_max_tree.sv -----
// range_assign_range_max_tree: top level, sequencer and shared compare unit
// depends on rarmt_pkg and rarmt_leaf_store
`timescale 1ns / 1ps

// Table of LEAVES (value, tag) leaves with range assign and range max query.
// An assign writes the pair to every leaf of the clipped inclusive range and
// gives no response; a query returns the largest pair (signed value, then tag)
// and found = 0 when the clipped range is empty. One request at a time: an
// assign writes and a query reads then compares each leaf of the range in turn,
// the query adding a response handoff, since the single memory port
// visits one leaf per step and one compare unit folds each read into the
// running best. After reset a clearing pass writes zero to every leaf,
// during which no request is accepted; csr writes are taken anytime.
module range_assign_range_max_tree #(
   parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  rarmt_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rarmt_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [rarmt_pkg::CSR_W-1:0]       csr_wdata
);
   import rarmt_pkg::*;

   localparam int IDX_W = $clog2(LEAVES);
   localparam int CNT_W = $clog2(LEAVES + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] leaves_ff, leaves_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   leaf_type         wval_ff, wval_in;
   leaf_type         best_ff, best_in;
   logic             got_ff, got_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [CMP_W-1:0] last_ext, lo_ext, hi_ext, lo_clip, hi_clip, wr_ext;
   logic             empty;
   logic             at_last;
   logic             mem_we;
   leaf_type         mem_wdata, mem_rdata;
   logic             better;
   logic             rsp_load;

   rarmt_leaf_store #(.LEAVES(LEAVES), .IDX_W(IDX_W)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (idx_ff),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // range clipping against the leaf bound
   always_comb begin
      last_ext = CMP_W'(leaves_ff) - CMP_W'(1);
      lo_ext   = CMP_W'(req_data.range_low);
      hi_ext   = CMP_W'(req_data.range_high);
      lo_clip  = (lo_ext > last_ext) ? last_ext : lo_ext;
      hi_clip  = (hi_ext > last_ext) ? last_ext : hi_ext;
      empty    = lo_clip > hi_clip;
   end

   assign accept  = req_valid && req_ready;
   assign at_last = (state_ff == ST_CLEAR) ? (idx_ff == IDX_W'(LEAVES - 1)) : (idx_ff == hi_ff);

   // shared compare unit: read leaf against running best
   assign better = !got_ff || (mem_rdata.value > best_ff.value) ||
                   ((mem_rdata.value == best_ff.value) && (mem_rdata.tag > best_ff.tag));

   // csr write, clamped to 1..LEAVES
   always_comb begin
      wr_ext    = CMP_W'(csr_wdata);
      leaves_in = leaves_ff;
      if (csr_we) begin
         priority if (wr_ext == '0) begin
            leaves_in = CNT_W'(1);
         end else if (wr_ext > CMP_W'(LEAVES)) begin
            leaves_in = CNT_W'(LEAVES);
         end else begin
            leaves_in = CNT_W'(wr_ext);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (at_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               priority if (empty) begin
                  state_in = (req_data.kind == KIND_ASSIGN) ? ST_IDLE : ST_RESP;
               end else if (req_data.kind == KIND_ASSIGN) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_WRITE: if (at_last) state_in = ST_IDLE;
         ST_READ:  state_in = ST_CMP;
         ST_CMP:   state_in = at_last ? ST_RESP : ST_READ;
         ST_RESP:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = wval_ff;
      idx_in    = idx_ff;
      hi_in     = hi_ff;
      wval_in   = wval_ff;
      best_in   = best_ff;
      got_in    = got_ff;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            idx_in    = idx_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               idx_in        = IDX_W'(lo_clip);
               hi_in         = IDX_W'(hi_clip);
               wval_in.value = req_data.new_value;
               wval_in.tag   = req_data.new_tag;
               best_in       = '0;
               got_in        = 1'b0;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            if (!at_last) idx_in = idx_ff + IDX_W'(1);
         end
         ST_READ: begin
         end
         ST_CMP: begin
            if (better) begin
               best_in = mem_rdata;
               got_in  = 1'b1;
            end
            if (!at_last) idx_in = idx_ff + IDX_W'(1);
         end
         ST_RESP: rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.max_value = got_ff ? best_ff.value : '0;
         rsp_in.max_tag   = got_ff ? best_ff.tag : '0;
         rsp_in.found     = got_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         leaves_ff    <= CNT_W'(LEAVES);
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         got_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         leaves_ff    <= leaves_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         got_ff       <= got_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      wval_ff <= wval_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside response state");

   a_bound_range: assert property (@(posedge clock) disable iff (reset)
      (leaves_ff != '0) && (CMP_W'(leaves_ff) <= CMP_W'(LEAVES)))
      else $error("leaf bound out of range");

   a_idx_le_hi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE || state_ff == ST_READ || state_ff == ST_CMP) |-> idx_ff <= hi_ff)
      else $error("walk index past range end");

   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

// ----- dv/range_assign_range_max_tree_tb.sv -----
// range_assign_range_max_tree_tb: self-checking bench for the range assign / range max table
// depends on rarmt_pkg and range_assign_range_max_tree
`timescale 1ns / 1ps

module range_assign_range_max_tree_tb;
   import rarmt_pkg::*;

   localparam int  TABLE_SIZE   = LEAVES_DEF;
   localparam int  SETTLE_WAIT  = 2 * TABLE_SIZE + 100;
   localparam int  LONG_HOLD    = 3000;
   localparam int  PHASE_ITEMS  = 235;
   localparam longint CYCLE_LIMIT = 64'd12_000_000;

   // leaf table kept flat, like the block's single leaf memory
   class max_pair_predictor;
      leaf_type   leaf_pair[TABLE_SIZE];
      int         bound;
      rsp_type    expected_max[$];
      int         mismatches;

      function void clear_table();
         foreach (leaf_pair[i]) leaf_pair[i] = '0;
         bound = TABLE_SIZE;
         mismatches = 0;
      endfunction

      function void set_bound(logic [CSR_W-1:0] n);
         int v;
         v = n;
         if (v == 0) v = 1;
         if (v > TABLE_SIZE) v = TABLE_SIZE;
         bound = v;
      endfunction

      function bit pair_above(leaf_type a, leaf_type b);
         if (a.value != b.value) return a.value > b.value;
         return a.tag > b.tag;
      endfunction

      function void note_request(req_type r);
         int lo, hi;
         rsp_type res;
         lo = r.range_low;
         hi = r.range_high;
         if (lo > bound - 1) lo = bound - 1;
         if (hi > bound - 1) hi = bound - 1;
         if (r.kind == KIND_ASSIGN) begin
            for (int i = lo; i <= hi; i++) begin
               leaf_pair[i].value = r.new_value;
               leaf_pair[i].tag   = r.new_tag;
            end
         end else begin
            res = '0;
            for (int i = lo; i <= hi; i++) begin
               if (!res.found || pair_above(leaf_pair[i], {res.max_value, res.max_tag})) begin
                  res.found     = 1'b1;
                  res.max_value = leaf_pair[i].value;
                  res.max_tag   = leaf_pair[i].tag;
               end
            end
            expected_max = {expected_max, res};
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (expected_max.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: value %0d tag %0d found %0b",
                        got.max_value, got.max_tag, got.found);
            return;
         end
         exp = expected_max.pop_front();
         if (got.max_value !== exp.max_value || got.max_tag !== exp.max_tag ||
             got.found !== exp.found) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: exp value %0d tag %0d found %0b, got %0d %0d %0b",
                        exp.max_value, exp.max_tag, exp.found,
                        got.max_value, got.max_tag, got.found);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_W-1:0]    csr_wdata;

   max_pair_predictor   table_model;
   longint              cycle_count;
   int                  burst_left;
   bit                  hold_request;
   bit                  hold_taken;
   int                  hold_left;
   int                  stall_mode_left;
   bit                  stall_mode;

   range_assign_range_max_tree i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: check, then pick next ready from stall pattern or long hold
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) table_model.check_result(rsp_data);
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = LONG_HOLD;
      end
      if (stall_mode_left == 0) begin
         stall_mode      = ($urandom_range(0, 2) != 0);
         stall_mode_left = $urandom_range(20, 300);
      end else begin
         stall_mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_mode) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_request(logic k, int lo, int hi, int v, int t);
      req_type r;
      r.kind       = k;
      r.range_low  = lo[RANGE_W-1:0];
      r.range_high = hi[RANGE_W-1:0];
      r.new_value  = v;
      r.new_tag    = t[TAG_W-1:0];
      return r;
   endfunction

   function automatic req_type random_request();
      int lo, hi, sel, v, t;
      logic k;
      k   = ($urandom_range(0, 9) < 4) ? KIND_ASSIGN : KIND_QUERY;
      lo  = $urandom_range(0, TABLE_SIZE - 1);
      sel = $urandom_range(0, 99);
      if (sel < 84) hi = lo + $urandom_range(0, 15);
      else if (sel < 94) hi = lo + $urandom_range(0, 127);
      else if (sel < 98) hi = $urandom_range(0, TABLE_SIZE - 1);
      else begin
         lo = 0;
         hi = TABLE_SIZE - 1;
      end
      if (hi > TABLE_SIZE - 1) hi = TABLE_SIZE - 1;
      // narrow value and tag sets make ties common
      v = ($urandom_range(0, 1) != 0) ? int'($urandom()) : $urandom_range(0, 4) - 2;
      t = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      return make_request(k, lo, hi, v, t);
   endfunction

   // offer one request in bursts with random gaps; valid stays up across a burst
   task automatic send_request(req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      table_model.note_request(r);
   endtask

   // wait for the block to drain, then write the leaf bound
   task automatic write_bound(logic [CSR_W-1:0] n);
      req_valid <= 1'b0;
      while (table_model.expected_max.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we    <= 1'b0;
      table_model.set_bound(n);
   endtask

   logic [CSR_W-1:0] bound_plan[8];

   initial begin
      table_model = new();
      table_model.clear_table();
      cycle_count     = 0;
      burst_left      = 0;
      hold_request    = 1'b0;
      hold_taken      = 1'b0;
      hold_left       = 0;
      stall_mode_left = 0;
      stall_mode      = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      bound_plan = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd17, 11'd512, 11'd1024, 11'd0};
      bound_plan[7] = $urandom_range(1, 2047);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ties and empty ranges
      write_bound(bound_plan[0]);
      send_request(make_request(KIND_QUERY, 0, 1023, -1, 65535));
      send_request(make_request(KIND_ASSIGN, 0, 1023, 32'h7fffffff, 65535));
      send_request(make_request(KIND_QUERY, 0, 1023, 0, 0));
      send_request(make_request(KIND_ASSIGN, 0, 0, 32'h80000000, 0));
      send_request(make_request(KIND_QUERY, 0, 0, 5, 5));
      send_request(make_request(KIND_QUERY, 0, 1, 0, 0));
      send_request(make_request(KIND_QUERY, 5, 3, 0, 0));
      send_request(make_request(KIND_ASSIGN, 9, 2, 77, 77));
      send_request(make_request(KIND_QUERY, 0, 1023, 0, 0));
      send_request(make_request(KIND_ASSIGN, 10, 20, 7, 3));
      send_request(make_request(KIND_ASSIGN, 15, 15, 7, 9));
      send_request(make_request(KIND_ASSIGN, 18, 18, -7, 65535));
      send_request(make_request(KIND_QUERY, 10, 20, 32'h12345678, 4321));
      send_request(make_request(KIND_QUERY, 16, 20, 0, 0));
      send_request(make_request(KIND_ASSIGN, 1023, 1023, -2, 1));
      send_request(make_request(KIND_QUERY, 1023, 1023, 0, 0));
      send_request(make_request(KIND_ASSIGN, 1, 1022, 0, 0));
      send_request(make_request(KIND_QUERY, 0, 1023, 0, 0));
      send_request(make_request(KIND_QUERY, 1023, 0, 0, 0));
      send_request(make_request(KIND_ASSIGN, 500, 520, 32'h55555555, 16'haaaa));
      send_request(make_request(KIND_QUERY, 490, 530, 0, 0));

      // random phases across leaf bounds
      for (int p = 0; p < 8; p++) begin
         if (p > 0) write_bound(bound_plan[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 2 && i == PHASE_ITEMS / 2) hold_request = 1'b1;
            if (i == PHASE_ITEMS / 3 && table_model.expected_max.size() != 0) begin
               // sender pause until the block has drained
               req_valid <= 1'b0;
               while (table_model.expected_max.size() != 0) @(posedge clock);
            end
            send_request(random_request());
         end
      end

      req_valid <= 1'b0;
      while (table_model.expected_max.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (table_model.mismatches == 0 && table_model.expected_max.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
